// ===== hw/rtl/uttcd_pkg.sv =====
// Shared widths and reset values for the Unix time to calendar date block.
package uttcd_pkg;

	localparam int UNIX_W  = 32;
	localparam int ZONE_W  = 17;
	localparam int LOCAL_W = 33;
	localparam int DAYS_W  = 17;
	localparam int SOD_W   = 17;
	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;

	localparam logic [ZONE_W-1:0] ZONE_RESET = ZONE_W'(28800);
	localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(1970);

endpackage

// ===== hw/rtl/uttcd_date.sv =====
// Day count since 1970 to Gregorian year, month and day, stages 4 to 7.
module uttcd_date (
	input  logic                          clk,
	input  logic                          en,
	input  logic [uttcd_pkg::DAYS_W-1:0]  days,
	output logic [uttcd_pkg::YEAR_W-1:0]  cal_year,
	output logic [uttcd_pkg::MONTH_W-1:0] cal_month,
	output logic [uttcd_pkg::DAY_W-1:0]   cal_day
);

	localparam int DW = uttcd_pkg::DAYS_W;

	// ceil(2^26 / 365): exact floor division for any 17-bit day count
	localparam logic [17:0] M365 = 18'd183860;

	localparam logic [8:0] MONTH_START [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// first day of year 1970+n; 2100 (n = 130) is not a leap year
	function automatic logic [DW-1:0] year_start(input logic [8:0] n);
		logic [DW-1:0] base;
		logic [DW-1:0] leaps;
		logic [DW-1:0] fix;
		base  = DW'(n) * DW'(365);
		leaps = DW'((n + 9'd1) >> 2);
		fix   = (n >= 9'd131) ? DW'(1) : DW'(0);
		return base + leaps - fix;
	endfunction

	// s4: estimate years as days / 365, true count is that or one less
	logic [34:0]   prod;
	logic [8:0]    e_s4;
	logic [DW-1:0] days_s4;

	assign prod = 35'(days) * 35'(M365);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s4    <= prod[34:26];
			days_s4 <= days;
		end
	end

	// s5: start days of both candidate years
	logic [8:0]    e_s5;
	logic [DW-1:0] days_s5;
	logic [DW-1:0] de_s5;
	logic [DW-1:0] dm_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s5    <= e_s4;
			days_s5 <= days_s4;
			de_s5   <= year_start(e_s4);
			dm_s5   <= year_start(e_s4 - 9'd1);
		end
	end

	// s6: pick the year, day of year, leap flag
	logic          take_prev;
	logic [8:0]    n_sel;
	logic [DW-1:0] doy_full;
	logic [7:0]    n_s6;
	logic [8:0]    doy_s6;
	logic          leap_s6;

	assign take_prev = days_s5 < de_s5;
	assign n_sel     = take_prev ? (e_s5 - 9'd1) : e_s5;
	assign doy_full  = days_s5 - (take_prev ? dm_s5 : de_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s6    <= n_sel[7:0];
			doy_s6  <= doy_full[8:0];
			leap_s6 <= (n_sel[1:0] == 2'd2) && (n_sel != 9'd130);
		end
	end

	// s7: month by parallel compares against month starts
	logic [8:0] st [12];
	logic [3:0] midx;
	logic [8:0] dom;

	always_comb begin
		for (int i = 0; i < 12; i++) begin
			st[i] = MONTH_START[i] + ((leap_s6 && i >= 2) ? 9'd1 : 9'd0);
		end
		midx = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s6 >= st[i]) begin
				midx = 4'(i);
			end
		end
		dom = doy_s6 - st[midx] + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cal_year  <= uttcd_pkg::EPOCH_YEAR + uttcd_pkg::YEAR_W'(n_s6);
			cal_month <= midx + 4'd1;
			cal_day   <= dom[uttcd_pkg::DAY_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/uttcd_clock.sv =====
// Second of day to hour, minute and second, stages 4 to 7.
module uttcd_clock (
	input  logic                         clk,
	input  logic                         en,
	input  logic [uttcd_pkg::SOD_W-1:0]  sod,
	output logic [uttcd_pkg::HOUR_W-1:0] clock_hour,
	output logic [uttcd_pkg::MIN_W-1:0]  clock_minute,
	output logic [uttcd_pkg::SEC_W-1:0]  clock_second
);

	localparam int SW = uttcd_pkg::SOD_W;

	// ceil(2^24 / 225) and ceil(2^16 / 15); the low bits are split off first
	localparam logic [16:0] M225 = 17'd74566;
	localparam logic [12:0] M15  = 13'd4370;

	// s4: hour = (sod >> 4) / 225
	logic [29:0]   hprod;
	logic [4:0]    hour_s4;
	logic [SW-1:0] sod_s4;

	assign hprod = 30'(sod[SW-1:4]) * 30'(M225);

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s4 <= hprod[28:24];
			sod_s4  <= sod;
		end
	end

	// s5: second of hour
	logic [SW-1:0] soh;
	logic [4:0]    hour_s5;
	logic [11:0]   rem_s5;

	assign soh = sod_s4 - SW'(hour_s4) * SW'(3600);

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s5 <= hour_s4;
			rem_s5  <= soh[11:0];
		end
	end

	// s6: minute = (rem >> 2) / 15
	logic [22:0] mprod;
	logic [4:0]  hour_s6;
	logic [11:0] rem_s6;
	logic [5:0]  min_s6;

	assign mprod = 23'(rem_s5[11:2]) * 23'(M15);

	always_ff @(posedge clk) begin
		if (en) begin
			hour_s6 <= hour_s5;
			rem_s6  <= rem_s5;
			min_s6  <= mprod[21:16];
		end
	end

	// s7
	logic [11:0] secs;

	assign secs = rem_s6 - 12'(min_s6) * 12'd60;

	always_ff @(posedge clk) begin
		if (en) begin
			clock_hour   <= hour_s6;
			clock_minute <= min_s6;
			clock_second <= secs[uttcd_pkg::SEC_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/unix_time_to_calendar_date.sv =====
// Top level: Unix seconds plus zone offset to calendar date and clock time.
//
// Usage:
//   Input channel (in_valid/in_ready) moves one word: unix_seconds, seconds
//   since 1970-01-01 00:00:00 UTC. Output channel (out_valid/out_ready)
//   moves one word per input: cal_year, cal_month, cal_day, clock_hour,
//   clock_minute, clock_second, in local time. Local time is unix_seconds +
//   zone_offset_seconds. Write the offset register via cfg_wr_en/cfg_wr_data
//   only while the pipeline is empty; the block does not enforce it. Reset
//   sets the offset to 28800 (eight hours) and empties the pipeline.
// Timing:
//   Seven register stages, s1 to s7. One word is accepted per cycle while
//   stage 7 is empty or out_ready is high; the depth is set by the two
//   reciprocal multiplies of the day split and the year estimate, each
//   followed by a correction.
// Stalls:
//   The whole pipeline advances together. When a result sits in stage 7 and
//   out_ready is low, every stage holds and in_ready drops; nothing is lost
//   or repeated. Empty stages (bubbles) do not hold back the stages ahead.
module unix_time_to_calendar_date (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [uttcd_pkg::ZONE_W-1:0]  cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [uttcd_pkg::UNIX_W-1:0]  unix_seconds,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [uttcd_pkg::YEAR_W-1:0]  cal_year,
	output logic [uttcd_pkg::MONTH_W-1:0] cal_month,
	output logic [uttcd_pkg::DAY_W-1:0]   cal_day,
	output logic [uttcd_pkg::HOUR_W-1:0]  clock_hour,
	output logic [uttcd_pkg::MIN_W-1:0]   clock_minute,
	output logic [uttcd_pkg::SEC_W-1:0]   clock_second
);

	localparam int LW = uttcd_pkg::LOCAL_W;
	localparam int DW = uttcd_pkg::DAYS_W;

	// floor(2^36 / 675); 86400 = 128 * 675, so days = (local >> 7) / 675.
	// The estimate is exact or one low; stage 3 corrects it.
	localparam logic [26:0] M675 = 27'd101806632;

	// offset register
	logic [uttcd_pkg::ZONE_W-1:0] zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= uttcd_pkg::ZONE_RESET;
		end else if (cfg_wr_en) begin
			zone_q <= cfg_wr_data;
		end
	end

	// one enable for all stages: move when the output slot is free or taken
	logic       en;
	logic [6:0] vld_q;   // vld_q[i] is the valid bit of stage i+1

	assign en        = !vld_q[6] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[5:0], in_valid};
		end
	end

	// s1: local time, at most 33 bits so no overflow
	logic [LW-1:0] local_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			local_s1 <= LW'(unix_seconds) + LW'(zone_q);
		end
	end

	// s2: day estimate by reciprocal multiply
	logic [52:0]   qprod;
	logic [LW-1:0] local_s2;
	logic [DW-1:0] qest_s2;

	assign qprod = 53'(local_s1[LW-1:7]) * 53'(M675);

	always_ff @(posedge clk) begin
		if (en) begin
			local_s2 <= local_s1;
			qest_s2  <= qprod[52:36];
		end
	end

	// s3: remainder check, one conditional step up
	logic [25:0]   rem_full;
	logic [10:0]   rem;
	logic          bump;
	logic [9:0]    rem_fix;
	logic [DW-1:0] days_s3;
	logic [uttcd_pkg::SOD_W-1:0] sod_s3;

	assign rem_full = local_s2[LW-1:7] - 26'(qest_s2) * 26'd675;
	assign rem      = rem_full[10:0];
	assign bump     = rem >= 11'd675;
	assign rem_fix  = bump ? 10'(rem - 11'd675) : rem[9:0];

	always_ff @(posedge clk) begin
		if (en) begin
			days_s3 <= qest_s2 + (bump ? DW'(1) : DW'(0));
			sod_s3  <= {rem_fix, local_s2[6:0]};
		end
	end

	// s4..s7: date and clock time in parallel
	uttcd_date u_date (
		.clk       (clk),
		.en        (en),
		.days      (days_s3),
		.cal_year  (cal_year),
		.cal_month (cal_month),
		.cal_day   (cal_day)
	);

	uttcd_clock u_clock (
		.clk          (clk),
		.en           (en),
		.sod          (sod_s3),
		.clock_hour   (clock_hour),
		.clock_minute (clock_minute),
		.clock_second (clock_second)
	);

endmodule

// ===== hw/rtl/uttcd_check.sv =====
// Port-level checks for the Unix time to calendar date block, bound to the top.
module uttcd_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [uttcd_pkg::YEAR_W-1:0]  cal_year,
	input logic [uttcd_pkg::MONTH_W-1:0] cal_month,
	input logic [uttcd_pkg::DAY_W-1:0]   cal_day,
	input logic [uttcd_pkg::HOUR_W-1:0]  clock_hour,
	input logic [uttcd_pkg::MIN_W-1:0]   clock_minute,
	input logic [uttcd_pkg::SEC_W-1:0]   clock_second
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cal_year) && $stable(cal_month)
			&& $stable(cal_day) && $stable(clock_hour) && $stable(clock_minute)
			&& $stable(clock_second))
		else $error("stalled result changed");

	// a free or draining output slot always lets a word in
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled with free output");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cal_year >= 12'd1970 && cal_year <= 12'd2106
			&& cal_month >= 4'd1 && cal_month <= 4'd12
			&& cal_day >= 5'd1 && cal_day <= 5'd31)
		else $error("date out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> clock_hour < 5'd24 && clock_minute < 6'd60 && clock_second < 6'd60)
		else $error("time out of range");

endmodule

bind unix_time_to_calendar_date uttcd_check u_check (.*);
